/* rtl/core/dsa_pkg.sv */
// Shared types, constants and the microcode table for the decimal scale align block.
package dsa_pkg;

    // Largest decimal scale; larger input scales are clamped to it.
    localparam logic [7:0] MAX_SCALE = 8'd28;

    // Width of one mantissa digit slice handled per divide step.
    localparam int CHUNK_BITS = 16;

    // Reciprocal of ten for 20-bit dividends: q = (x * DIV10_MUL) >> DIV10_SHIFT.
    localparam int DIV10_SHIFT = 23;
    localparam logic [39:0] DIV10_MUL = 40'd838861;

    // Request operations.
    localparam logic OP_ALIGN  = 1'b0;
    localparam logic OP_REDUCE = 1'b1;

    // Microprogram step addresses.
    typedef enum logic [2:0] {
        P_LOAD     = 3'd0,
        P_DISPATCH = 3'd1,
        P_ALIGN    = 3'd2,
        P_RED_INIT = 3'd3,
        P_DIV      = 3'd4,
        P_EMIT     = 3'd5
    } step_t;

    // Datapath action of one control word.
    typedef enum logic [2:0] {
        A_NONE     = 3'd0,
        A_LOAD     = 3'd1,
        A_MUL      = 3'd2,
        A_RED_INIT = 3'd3,
        A_DIV      = 3'd4,
        A_EMIT     = 3'd5
    } action_t;

    // Branch condition of one control word.
    typedef enum logic [2:0] {
        C_REQ        = 3'd0,
        C_REDUCE     = 3'd1,
        C_ALIGN_STOP = 3'd2,
        C_SHIFT_ZERO = 3'd3,
        C_DIV_DONE   = 3'd4,
        C_OUT_BUSY   = 3'd5
    } cond_t;

    // One control word: action, condition, and the two branch targets.
    typedef struct packed {
        action_t action;
        cond_t   cond;
        step_t   jump_true;
        step_t   jump_false;
    } ctrl_word_t;

    // Microcode ROM.
    function automatic ctrl_word_t ucode(input step_t pc);
        ctrl_word_t w;
        case (pc)
            P_LOAD:     w = '{A_LOAD,     C_REQ,        P_DISPATCH, P_LOAD};
            P_DISPATCH: w = '{A_NONE,     C_REDUCE,     P_RED_INIT, P_ALIGN};
            P_ALIGN:    w = '{A_MUL,      C_ALIGN_STOP, P_EMIT,     P_ALIGN};
            P_RED_INIT: w = '{A_RED_INIT, C_SHIFT_ZERO, P_EMIT,     P_DIV};
            P_DIV:      w = '{A_DIV,      C_DIV_DONE,   P_EMIT,     P_DIV};
            P_EMIT:     w = '{A_EMIT,     C_OUT_BUSY,   P_EMIT,     P_LOAD};
            default:    w = '{A_NONE,     C_REQ,        P_LOAD,     P_LOAD};
        endcase
        return w;
    endfunction

    // Clamp an input scale to the largest legal scale.
    function automatic logic [4:0] clamp_scale(input logic [4:0] s);
        logic [4:0] r;
        if ({3'd0, s} > MAX_SCALE) begin
            r = MAX_SCALE[4:0];
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

/* rtl/core/decimal_scale_align_top.sv */
// Microcoded scale alignment and scale reduction unit for unsigned decimals.
// Align: for a scale difference d, one times-ten per cycle through a single wide
// shift-add unit, stopping early on a times-ten overflow.
// Reduce: for s dropped digits, one 16-bit slice per cycle. One request at a time; the
// next is taken once the previous result has been loaded into the output register.
// Synchronous active-low reset idles the sequencer and empties the output register.
module decimal_scale_align_top #(
    parameter int MANTISSA_WORDS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_a_lo,
    input  logic [31:0] s_a_hi,
    input  logic [4:0]  s_a_scale,
    input  logic [63:0] s_b_lo,
    input  logic [31:0] s_b_hi,
    input  logic [4:0]  s_b_scale,
    input  logic [4:0]  s_shift,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_res_a_lo,
    output logic [31:0] m_res_a_hi,
    output logic [4:0]  m_res_a_scale,
    output logic [63:0] m_res_b_lo,
    output logic [31:0] m_res_b_hi,
    output logic [4:0]  m_res_b_scale,
    output logic        m_overflow
);

    localparam int MBITS = MANTISSA_WORDS * 32;
    localparam int NCHUNK = MBITS / dsa_pkg::CHUNK_BITS;
    localparam int IW = $clog2(NCHUNK);
    localparam logic [IW-1:0] TOP_CHUNK = IW'(NCHUNK - 1);

    // Sequencer and datapath registers.
    dsa_pkg::step_t    pc_reg, pc_next;
    logic [MBITS-1:0]  a_reg, a_next;
    logic [MBITS-1:0]  b_reg, b_next;
    logic [4:0]        a_scale_reg, a_scale_next;
    logic [4:0]        b_scale_reg, b_scale_next;
    logic              op_reg, op_next;
    logic [4:0]        shift_reg, shift_next;
    logic              ovf_reg, ovf_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [3:0]        rem_reg, rem_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       res_a_lo_reg, res_a_lo_next;
    logic [31:0]       res_a_hi_reg, res_a_hi_next;
    logic [4:0]        res_a_scale_reg, res_a_scale_next;
    logic [63:0]       res_b_lo_reg, res_b_lo_next;
    logic [31:0]       res_b_hi_reg, res_b_hi_next;
    logic [4:0]        res_b_scale_reg, res_b_scale_next;
    logic              res_ovf_reg, res_ovf_next;

    // Datapath signals.
    dsa_pkg::ctrl_word_t cw;
    logic              cond_hit;
    logic              out_busy;
    logic              scale_eq;
    logic              a_lower;
    logic [MBITS-1:0]  mul_src;
    logic [MBITS+3:0]  mul_prod;
    logic              mul_ovf;
    logic [4:0]        red_sh;
    logic [15:0]       chunk;
    logic [19:0]       div_cur;
    logic [39:0]       div_prod;
    logic [15:0]       div_q;
    logic [19:0]       div_q10;
    logic [3:0]        div_r;
    logic [127:0]      load_a, load_b;
    logic [127:0]      emit_a, emit_b;

    // Fetch the control word of the current step.
    assign cw = dsa_pkg::ucode(pc_reg);
    assign out_busy = m_valid_reg && !m_ready;
    assign s_ready = (pc_reg == dsa_pkg::P_LOAD);

    // Times-ten unit on the operand with the lower scale.
    assign scale_eq = (a_scale_reg == b_scale_reg);
    assign a_lower = (a_scale_reg < b_scale_reg);
    assign mul_src = a_lower ? a_reg : b_reg;
    assign mul_prod = ({4'd0, mul_src} << 3) + ({4'd0, mul_src} << 1);
    assign mul_ovf = |mul_prod[MBITS+3:MBITS];

    // Effective reduce shift saturates at a's scale.
    assign red_sh = (shift_reg > a_scale_reg) ? a_scale_reg : shift_reg;

    // Divide-by-ten unit on one 16-bit slice with the running remainder.
    assign chunk = a_reg[idx_reg * dsa_pkg::CHUNK_BITS +: dsa_pkg::CHUNK_BITS];
    assign div_cur = {rem_reg, chunk};
    assign div_prod = 40'(div_cur) * dsa_pkg::DIV10_MUL;
    assign div_q = div_prod[dsa_pkg::DIV10_SHIFT +: 16];
    assign div_q10 = 20'({div_q, 3'd0}) + 20'({div_q, 1'd0});
    assign div_r = 4'(div_cur - div_q10);

    // Input words placed into the mantissa width; output words zero-padded.
    assign load_a = {32'd0, s_a_hi, s_a_lo};
    assign load_b = {32'd0, s_b_hi, s_b_lo};
    assign emit_a = 128'(a_reg);
    assign emit_b = 128'(b_reg);

    // Branch condition select.
    always_comb begin
        case (cw.cond)
            dsa_pkg::C_REQ:        cond_hit = s_valid;
            dsa_pkg::C_REDUCE:     cond_hit = (op_reg == dsa_pkg::OP_REDUCE);
            dsa_pkg::C_ALIGN_STOP: cond_hit = scale_eq || mul_ovf;
            dsa_pkg::C_SHIFT_ZERO: cond_hit = (red_sh == 5'd0);
            dsa_pkg::C_DIV_DONE:   cond_hit = (idx_reg == '0) && (cnt_reg == 5'd1);
            dsa_pkg::C_OUT_BUSY:   cond_hit = out_busy;
            default:               cond_hit = 1'b0;
        endcase
    end

    // Next step address.
    always_comb begin
        pc_next = cond_hit ? cw.jump_true : cw.jump_false;
    end

    // Datapath actions.
    always_comb begin
        a_next       = a_reg;
        b_next       = b_reg;
        a_scale_next = a_scale_reg;
        b_scale_next = b_scale_reg;
        op_next      = op_reg;
        shift_next   = shift_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        case (cw.action)
            dsa_pkg::A_LOAD: begin
                if (s_valid) begin
                    a_next       = load_a[MBITS-1:0];
                    b_next       = load_b[MBITS-1:0];
                    a_scale_next = dsa_pkg::clamp_scale(s_a_scale);
                    b_scale_next = dsa_pkg::clamp_scale(s_b_scale);
                    op_next      = s_op;
                    shift_next   = s_shift;
                    ovf_next     = 1'b0;
                end
            end
            dsa_pkg::A_MUL: begin
                if (!scale_eq) begin
                    if (mul_ovf) begin
                        ovf_next = 1'b1;
                    end else if (a_lower) begin
                        a_next       = mul_prod[MBITS-1:0];
                        a_scale_next = a_scale_reg + 5'd1;
                    end else begin
                        b_next       = mul_prod[MBITS-1:0];
                        b_scale_next = b_scale_reg + 5'd1;
                    end
                end
            end
            dsa_pkg::A_RED_INIT: begin
                cnt_next     = red_sh;
                a_scale_next = a_scale_reg - red_sh;
                idx_next     = TOP_CHUNK;
                rem_next     = 4'd0;
            end
            dsa_pkg::A_DIV: begin
                a_next[idx_reg * dsa_pkg::CHUNK_BITS +: dsa_pkg::CHUNK_BITS] = div_q;
                if (idx_reg == '0) begin
                    // Last slice of this digit: start the next divide from the top.
                    cnt_next = cnt_reg - 5'd1;
                    idx_next = TOP_CHUNK;
                    rem_next = 4'd0;
                end else begin
                    idx_next = idx_reg - IW'(1);
                    rem_next = div_r;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded at the emit step once the previous result is taken.
    always_comb begin
        m_valid_next      = m_valid_reg && !m_ready;
        res_a_lo_next     = res_a_lo_reg;
        res_a_hi_next     = res_a_hi_reg;
        res_a_scale_next  = res_a_scale_reg;
        res_b_lo_next     = res_b_lo_reg;
        res_b_hi_next     = res_b_hi_reg;
        res_b_scale_next  = res_b_scale_reg;
        res_ovf_next      = res_ovf_reg;
        if (cw.action == dsa_pkg::A_EMIT && !out_busy) begin
            m_valid_next     = 1'b1;
            res_a_lo_next    = emit_a[63:0];
            res_a_hi_next    = emit_a[95:64];
            res_a_scale_next = a_scale_reg;
            res_b_lo_next    = emit_b[63:0];
            res_b_hi_next    = emit_b[95:64];
            res_b_scale_next = b_scale_reg;
            res_ovf_next     = ovf_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= dsa_pkg::P_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        a_reg           <= a_next;
        b_reg           <= b_next;
        a_scale_reg     <= a_scale_next;
        b_scale_reg     <= b_scale_next;
        op_reg          <= op_next;
        shift_reg       <= shift_next;
        ovf_reg         <= ovf_next;
        cnt_reg         <= cnt_next;
        idx_reg         <= idx_next;
        rem_reg         <= rem_next;
        res_a_lo_reg    <= res_a_lo_next;
        res_a_hi_reg    <= res_a_hi_next;
        res_a_scale_reg <= res_a_scale_next;
        res_b_lo_reg    <= res_b_lo_next;
        res_b_hi_reg    <= res_b_hi_next;
        res_b_scale_reg <= res_b_scale_next;
        res_ovf_reg     <= res_ovf_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_res_a_lo    = res_a_lo_reg;
    assign m_res_a_hi    = res_a_hi_reg;
    assign m_res_a_scale = res_a_scale_reg;
    assign m_res_b_lo    = res_b_lo_reg;
    assign m_res_b_hi    = res_b_hi_reg;
    assign m_res_b_scale = res_b_scale_reg;
    assign m_overflow    = res_ovf_reg;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the decimal scale align unit: directed table, then random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MANT_BITS      = 96;
    localparam logic [4:0]  TOP_SCALE      = dsa_pkg::MAX_SCALE[4:0];
    localparam int          RANDOM_ITEMS   = 550;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 300;

    localparam logic [95:0] ALL_ONES       = {96{1'b1}};
    localparam logic [95:0] TENTH_OF_FULL  = ALL_ONES / 96'd10;
    localparam logic [95:0] TEN_POW_28     = 96'd10_000_000_000_000_000_000_000_000_000;

    // One request as the sender presents it.
    typedef struct packed {
        logic        op;
        logic [95:0] a;
        logic [4:0]  a_scale;
        logic [95:0] b;
        logic [4:0]  b_scale;
        logic [4:0]  shift;
    } scale_req_t;

    // The pair of decimals and the flag that one request produces.
    typedef struct packed {
        logic [95:0] a;
        logic [4:0]  a_scale;
        logic [95:0] b;
        logic [4:0]  b_scale;
        logic        ovf;
    } scaled_pair_t;

    // One row of the directed table; typed rows carry their result inline.
    typedef struct packed {
        scale_req_t   req;
        logic         typed;
        scaled_pair_t given;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [63:0] s_a_lo;
    logic [31:0] s_a_hi;
    logic [4:0]  s_a_scale;
    logic [63:0] s_b_lo;
    logic [31:0] s_b_hi;
    logic [4:0]  s_b_scale;
    logic [4:0]  s_shift;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_res_a_lo;
    logic [31:0] m_res_a_hi;
    logic [4:0]  m_res_a_scale;
    logic [63:0] m_res_b_lo;
    logic [31:0] m_res_b_hi;
    logic [4:0]  m_res_b_scale;
    logic        m_overflow;

    scaled_pair_t  scaled_pairs_due[$];
    directed_row_t directed_rows[$];
    scaled_pair_t  head_pair;
    scale_req_t    rand_req;
    scaled_pair_t  no_pair;

    int mismatches     = 0;
    int requests_sent  = 0;
    int reduce_sent    = 0;
    int results_seen   = 0;
    int overflows_seen = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    int ready_cycle    = 0;

    decimal_scale_align_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_a_lo        (s_a_lo),
        .s_a_hi        (s_a_hi),
        .s_a_scale     (s_a_scale),
        .s_b_lo        (s_b_lo),
        .s_b_hi        (s_b_hi),
        .s_b_scale     (s_b_scale),
        .s_shift       (s_shift),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res_a_lo    (m_res_a_lo),
        .m_res_a_hi    (m_res_a_hi),
        .m_res_a_scale (m_res_a_scale),
        .m_res_b_lo    (m_res_b_lo),
        .m_res_b_hi    (m_res_b_hi),
        .m_res_b_scale (m_res_b_scale),
        .m_overflow    (m_overflow)
    );

    // Free-running clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Scales above the legal range behave as the largest scale.
    function automatic logic [4:0] limit_scale(input logic [4:0] s);
        return (s > TOP_SCALE) ? TOP_SCALE : s;
    endfunction

    // Multiply a mantissa by ten; returns 0 and leaves the value alone on carry out.
    function automatic bit mul10_fits(input logic [95:0] m, output logic [95:0] r);
        logic [99:0] prod;
        prod = {4'd0, m} * 100'd10;
        r = m;
        if (prod[99:96] != 4'd0) begin
            return 1'b0;
        end
        r = prod[95:0];
        return 1'b1;
    endfunction

    // Compute the aligned or reduced pair that a request must produce.
    function automatic scaled_pair_t predict_scaled_pair(input scale_req_t r);
        scaled_pair_t p;
        logic [95:0]  next;
        logic [4:0]   drop;
        p.a       = r.a;
        p.b       = r.b;
        p.a_scale = limit_scale(r.a_scale);
        p.b_scale = limit_scale(r.b_scale);
        p.ovf     = 1'b0;
        if (r.op == dsa_pkg::OP_ALIGN) begin
            // Raise the lower-scale operand one digit at a time until the scales meet.
            while (p.a_scale < p.b_scale && !p.ovf) begin
                if (mul10_fits(p.a, next)) begin
                    p.a       = next;
                    p.a_scale = p.a_scale + 5'd1;
                end else begin
                    p.ovf = 1'b1;
                end
            end
            while (p.b_scale < p.a_scale && !p.ovf) begin
                if (mul10_fits(p.b, next)) begin
                    p.b       = next;
                    p.b_scale = p.b_scale + 5'd1;
                end else begin
                    p.ovf = 1'b1;
                end
            end
        end else begin
            // Drop digits from a, never more than its scale allows.
            drop = (r.shift > p.a_scale) ? p.a_scale : r.shift;
            for (int i = 0; i < drop; i++) begin
                p.a = p.a / 96'd10;
            end
            p.a_scale = p.a_scale - drop;
        end
        return p;
    endfunction

    // Mantissas from several classes: full random, small, extremes, near the carry boundary.
    function automatic logic [95:0] random_mantissa();
        logic [95:0] m;
        int          digits;
        case ($urandom_range(0, 5))
            0: m = {$urandom, $urandom, $urandom};
            1: m = 96'($urandom_range(0, 1000));
            2: m = ALL_ONES;
            3: begin
                m = ALL_ONES;
                digits = $urandom_range(1, 28);
                for (int i = 0; i < digits; i++) begin
                    m = m / 96'd10;
                end
                m = m + 96'($urandom_range(0, 3)) - 96'd1;
            end
            4: m = {$urandom, $urandom, $urandom} >> $urandom_range(0, MANT_BITS - 1);
            default: m = '0;
        endcase
        return m;
    endfunction

    // Mostly legal scales, with some above the range to exercise clamping.
    function automatic logic [4:0] random_scale();
        if ($urandom_range(0, 9) == 0) begin
            return 5'($urandom_range(29, 31));
        end
        return 5'($urandom_range(0, 28));
    endfunction

    function automatic scale_req_t random_request();
        scale_req_t r;
        r.op      = 1'($urandom_range(0, 1));
        r.a       = random_mantissa();
        r.b       = random_mantissa();
        r.a_scale = random_scale();
        r.b_scale = random_scale();
        case ($urandom_range(0, 9))
            7, 8:    r.shift = 5'($urandom_range(7, 28));
            9:       r.shift = 5'($urandom_range(29, 31));
            default: r.shift = 5'($urandom_range(0, 6));
        endcase
        // A small low-scale operand lets alignment run further before any carry out.
        if (r.op == dsa_pkg::OP_ALIGN && $urandom_range(0, 3) == 0) begin
            if (r.a_scale < r.b_scale) begin
                r.a = 96'($urandom_range(0, 99));
            end else begin
                r.b = 96'($urandom_range(0, 99));
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic op, input logic [95:0] a, input logic [4:0] a_scale,
                           input logic [95:0] b, input logic [4:0] b_scale,
                           input logic [4:0] shift, input logic typed,
                           input logic [95:0] want_a, input logic [4:0] want_a_scale,
                           input logic [95:0] want_b, input logic [4:0] want_b_scale,
                           input logic want_ovf);
        directed_row_t row;
        row.req   = '{op, a, a_scale, b, b_scale, shift};
        row.typed = typed;
        row.given = '{want_a, want_a_scale, want_b, want_b_scale, want_ovf};
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH result %0d at %0t ns: %s", results_seen, $time, what);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
        end
    endtask

    // Present one request, record its expected result, then idle as the burst pattern says.
    task automatic send_request(input scale_req_t r, input logic typed,
                                input scaled_pair_t given, input bit hold);
        s_valid   <= 1'b1;
        s_op      <= r.op;
        s_a_lo    <= r.a[63:0];
        s_a_hi    <= r.a[95:64];
        s_a_scale <= r.a_scale;
        s_b_lo    <= r.b[63:0];
        s_b_hi    <= r.b[95:64];
        s_b_scale <= r.b_scale;
        s_shift   <= r.shift;
        do @(posedge aclk); while (!(s_valid && s_ready));
        scaled_pairs_due.push_back(typed ? given : predict_scaled_pair(r));
        requests_sent++;
        if (r.op == dsa_pkg::OP_REDUCE) begin
            reduce_sent++;
        end
        if (hold || burst_left == 0) begin
            s_valid <= 1'b0;
            if (hold) begin
                // Let the unit drain completely before the next request.
                @(posedge aclk);
                while (scaled_pairs_due.size() != 0) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver back-pressure cycles through always-ready, random, sparse and mostly-ready phases.
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        case ((ready_cycle / 97) % 4)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (ready_cycle % 4 == 0);
            default: m_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Check each accepted result against the oldest outstanding expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (scaled_pairs_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                head_pair = scaled_pairs_due.pop_front();
                compare_field("res_a_lo", m_res_a_lo, head_pair.a[63:0]);
                compare_field("res_a_hi", 64'(m_res_a_hi), 64'(head_pair.a[95:64]));
                compare_field("res_a_scale", 64'(m_res_a_scale), 64'(head_pair.a_scale));
                compare_field("res_b_lo", m_res_b_lo, head_pair.b[63:0]);
                compare_field("res_b_hi", 64'(m_res_b_hi), 64'(head_pair.b[95:64]));
                compare_field("res_b_scale", 64'(m_res_b_scale), 64'(head_pair.b_scale));
                compare_field("overflow", 64'(m_overflow), 64'(head_pair.ovf));
            end
            results_seen++;
            if (m_overflow) begin
                overflows_seen++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves a request for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Main sequence: reset, directed table, random requests, drain and verdict.
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_op      <= dsa_pkg::OP_ALIGN;
        s_a_lo    <= '0;
        s_a_hi    <= '0;
        s_a_scale <= '0;
        s_b_lo    <= '0;
        s_b_hi    <= '0;
        s_b_scale <= '0;
        s_shift   <= '0;
        m_ready   <= 1'b0;
        no_pair   = '0;

        // Zero operands at zero scale pass straight through.
        add_row(dsa_pkg::OP_ALIGN, '0, 5'd0, '0, 5'd0, 5'd0, 1'b1,
                '0, 5'd0, '0, 5'd0, 1'b0);
        // The largest mantissa cannot take even one times-ten step.
        add_row(dsa_pkg::OP_ALIGN, ALL_ONES, 5'd0, '0, 5'd5, 5'd0, 1'b1,
                ALL_ONES, 5'd0, '0, 5'd5, 1'b1);
        add_row(dsa_pkg::OP_ALIGN, ALL_ONES, 5'd3, ALL_ONES, 5'd2, 5'd0, 1'b1,
                ALL_ONES, 5'd3, ALL_ONES, 5'd2, 1'b1);
        // Equal scales leave both operands alone.
        add_row(dsa_pkg::OP_ALIGN, 96'h1234_5678_9ABC_DEF0_0FED_CBA9, 5'd28,
                96'h8765_4321_0000_FFFF_AAAA_5555, 5'd28, 5'd0, 1'b1,
                96'h1234_5678_9ABC_DEF0_0FED_CBA9, 5'd28,
                96'h8765_4321_0000_FFFF_AAAA_5555, 5'd28, 1'b0);
        // Out-of-range scales clamp and then compare equal.
        add_row(dsa_pkg::OP_ALIGN, 96'd42, 5'd31, 96'd7, 5'd28, 5'd0, 1'b1,
                96'd42, 5'd28, 96'd7, 5'd28, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, 96'd5, 5'd30, 96'd6, 5'd29, 5'd0, 1'b1,
                96'd5, 5'd28, 96'd6, 5'd28, 1'b0);
        // Full-depth alignment, right up to and past the carry boundary.
        add_row(dsa_pkg::OP_ALIGN, 96'd1, 5'd0, 96'd1, 5'd28, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, ALL_ONES, 5'd28, 96'd1, 5'd0, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, 96'd7, 5'd0, 96'd3, 5'd28, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, 96'd9, 5'd0, 96'd3, 5'd28, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, 96'd3, 5'd0, 96'd11, 5'd31, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, TENTH_OF_FULL, 5'd0, 96'd1, 5'd1, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_ALIGN, TENTH_OF_FULL + 96'd1, 5'd0, 96'd1, 5'd2, 5'd0, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        // Reduce: no shift, shift saturating at zero scale, clamped b.
        add_row(dsa_pkg::OP_REDUCE, ALL_ONES, 5'd9, 96'd77, 5'd3, 5'd0, 1'b1,
                ALL_ONES, 5'd9, 96'd77, 5'd3, 1'b0);
        add_row(dsa_pkg::OP_REDUCE, 96'd999, 5'd0, ALL_ONES, 5'd0, 5'd5, 1'b1,
                96'd999, 5'd0, ALL_ONES, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_REDUCE, 96'd12345, 5'd3, 96'd777, 5'd30, 5'd31, 1'b1,
                96'd12, 5'd0, 96'd777, 5'd28, 1'b0);
        add_row(dsa_pkg::OP_REDUCE, TEN_POW_28, 5'd28, '0, 5'd0, 5'd28, 1'b1,
                96'd1, 5'd0, '0, 5'd0, 1'b0);
        // Reduce of wide values over many digits, with clamped a scale.
        add_row(dsa_pkg::OP_REDUCE, ALL_ONES, 5'd28, TEN_POW_28, 5'd28, 5'd28, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_REDUCE, ALL_ONES, 5'd31, 96'd1, 5'd1, 5'd1, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_REDUCE, 96'hFFFF_0000_FFFF_0000_FFFF_0000, 5'd20,
                96'd5, 5'd17, 5'd16, 1'b0, '0, 5'd0, '0, 5'd0, 1'b0);
        add_row(dsa_pkg::OP_REDUCE, 96'd123456789, 5'd12, 96'd8, 5'd31, 5'd29, 1'b0,
                '0, 5'd0, '0, 5'd0, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].given, 1'b0);
        end

        // Random requests; one in the middle waits for the unit to drain, the last too.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            rand_req = random_request();
            send_request(rand_req, 1'b0, no_pair,
                         (n == RANDOM_ITEMS / 2) || (n == RANDOM_ITEMS - 1));
        end

        while (scaled_pairs_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (scaled_pairs_due.size() != 0) begin
            report_mismatch("expected results still outstanding at end of run");
        end

        $display("Sent %0d requests (%0d align, %0d reduce); checked %0d results, %0d overflowed.",
                 requests_sent, requests_sent - reduce_sent, reduce_sent,
                 results_seen, overflows_seen);
        $display("Mismatches found: %0d", mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
